// File: rtl/pbrm_pkg.sv
// ----------------------------------------------------------------------------
// pbrm_pkg: shared types and constants of the per-bin statistics block
// Field widths, bin count, derived index width, divider geometry, state enum, controller/datapath structs.
// ----------------------------------------------------------------------------
package pbrm_pkg;

	localparam int NUM_BINS = 7;
	localparam int BIN_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

	localparam int DAY_W   = 3;
	localparam int CNT_W   = 16;
	localparam int PRES_W  = 17;
	localparam int TEMP_W  = 16;

	// Divider geometry: quotient never exceeds PRES_W bits, dividend magnitude
	// stays below divisor * 2**QUO_W.
	localparam int QUO_W   = PRES_W;
	localparam int DVD_W   = CNT_W + QUO_W;
	localparam int STEP_W  = $clog2(QUO_W + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIVP,
		ST_DIVP_WAIT,
		ST_DIVT,
		ST_DIVT_WAIT,
		ST_WRITE
	} pbrm_state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic div_start;
		logic div_temp;
		logic cap_mean;
		logic write;
	} pbrm_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
	} pbrm_status_t;

endpackage

// File: rtl/pbrm_in_if.sv
// ----------------------------------------------------------------------------
// pbrm_in_if: sample channel
// Valid/ready channel carrying one sample item per transfer.
// ----------------------------------------------------------------------------
interface pbrm_in_if import pbrm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [DAY_W-1:0]         day_bin;
	logic [CNT_W-1:0]         sample_count;
	logic [PRES_W-1:0]        pressure_sample;
	logic signed [TEMP_W-1:0] temp_sample;

	modport source (output valid, day_bin, sample_count, pressure_sample, temp_sample,
		input ready);
	modport sink (input valid, day_bin, sample_count, pressure_sample, temp_sample,
		output ready);
endinterface

// File: rtl/pbrm_out_if.sv
// ----------------------------------------------------------------------------
// pbrm_out_if: result channel
// Valid/ready channel carrying the updated statistics of one bin.
// ----------------------------------------------------------------------------
interface pbrm_out_if import pbrm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [PRES_W-1:0]        pressure_mean;
	logic [PRES_W-1:0]        pressure_least;
	logic [PRES_W-1:0]        pressure_most;
	logic signed [TEMP_W-1:0] temp_mean;
	logic signed [TEMP_W-1:0] temp_least;
	logic signed [TEMP_W-1:0] temp_most;

	modport source (output valid, pressure_mean, pressure_least, pressure_most,
		temp_mean, temp_least, temp_most, input ready);
	modport sink (input valid, pressure_mean, pressure_least, pressure_most,
		temp_mean, temp_least, temp_most, output ready);
endinterface

// File: rtl/pbrm_div.sv
// ----------------------------------------------------------------------------
// pbrm_div: serial restoring divider
// One quotient bit per cycle; QUO_W steps after start, then a done pulse.
// ----------------------------------------------------------------------------
module pbrm_div import pbrm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic [QUO_W-1:0]  quotient,
	output logic              busy,
	output logic              done
);

	logic [CNT_W-1:0]  rem_q;
	logic [QUO_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DVD_W-1:QUO_W];
			dvd_q <= dividend[QUO_W-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			// shift in next dividend bit, subtract when it fits
			rem_q <= fits ? CNT_W'(trial - {1'b0, dsr_q}) : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], fits};
		end
	end

	assign quotient = dvd_q;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

// File: rtl/pbrm_datapath.sv
// ----------------------------------------------------------------------------
// pbrm_datapath: bin stores, mean accumulators, min/max and result register
// Driven step by step by the controller through a command struct.
// ----------------------------------------------------------------------------
module pbrm_datapath import pbrm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pbrm_cmd_t                cmd,
	output pbrm_status_t             st,
	input  logic [DAY_W-1:0]         day_bin,
	input  logic [CNT_W-1:0]         sample_count,
	input  logic [PRES_W-1:0]        pressure_sample,
	input  logic signed [TEMP_W-1:0] temp_sample,
	output logic [PRES_W-1:0]        pressure_mean,
	output logic [PRES_W-1:0]        pressure_least,
	output logic [PRES_W-1:0]        pressure_most,
	output logic signed [TEMP_W-1:0] temp_mean,
	output logic signed [TEMP_W-1:0] temp_least,
	output logic signed [TEMP_W-1:0] temp_most
);

	// per-bin stores
	logic [PRES_W-1:0]        pmean_mem [NUM_BINS];
	logic [PRES_W-1:0]        pmin_mem  [NUM_BINS];
	logic [PRES_W-1:0]        pmax_mem  [NUM_BINS];
	logic signed [TEMP_W-1:0] tmean_mem [NUM_BINS];
	logic signed [TEMP_W-1:0] tmin_mem  [NUM_BINS];
	logic signed [TEMP_W-1:0] tmax_mem  [NUM_BINS];

	// captured item
	logic [BIN_W-1:0]         bin_q;
	logic                     bad_q;
	logic [CNT_W-1:0]         n_q;
	logic [PRES_W-1:0]        p_q;
	logic signed [TEMP_W-1:0] t_q;

	// after the multiply step
	logic [DVD_W-1:0]         pacc_q;
	logic [DVD_W-1:0]         tmag_q;
	logic                     tneg_q;
	logic [PRES_W-1:0]        pmin_q, pmax_q;
	logic signed [TEMP_W-1:0] tmin_q, tmax_q;

	// divided means
	logic [PRES_W-1:0]        pmean_q;
	logic signed [TEMP_W-1:0] tmean_q;

	// result register
	logic [PRES_W-1:0]        res_pmean_q, res_pmin_q, res_pmax_q;
	logic signed [TEMP_W-1:0] res_tmean_q, res_tmin_q, res_tmax_q;

	logic                     in_bad;
	logic [CNT_W-1:0]         n_m1;
	logic [DVD_W-1:0]         pprod;
	logic signed [DVD_W-1:0]  tprod;
	logic signed [DVD_W:0]    tacc;
	logic signed [DVD_W:0]    tacc_neg;
	logic [PRES_W-1:0]        rd_pmean, rd_pmin, rd_pmax;
	logic signed [TEMP_W-1:0] rd_tmean, rd_tmin, rd_tmax;
	logic [DVD_W-1:0]         div_dividend;
	logic [QUO_W-1:0]         div_quo;
	logic                     div_busy;
	logic                     div_done;

	assign in_bad = (32'(day_bin) >= NUM_BINS);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= in_bad ? '0 : BIN_W'(day_bin);
			n_q   <= (sample_count == '0) ? CNT_W'(1) : sample_count;
			p_q   <= pressure_sample;
			t_q   <= temp_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q <= 1'b0;
		end else if (cmd.load) begin
			bad_q <= in_bad;
		end
	end

	assign rd_pmean = pmean_mem[bin_q];
	assign rd_pmin  = pmin_mem[bin_q];
	assign rd_pmax  = pmax_mem[bin_q];
	assign rd_tmean = tmean_mem[bin_q];
	assign rd_tmin  = tmin_mem[bin_q];
	assign rd_tmax  = tmax_mem[bin_q];

	assign n_m1     = n_q - 1'b1;
	assign pprod    = DVD_W'(rd_pmean) * DVD_W'(n_m1);
	assign tprod    = DVD_W'(rd_tmean) * DVD_W'($signed({1'b0, n_m1}));
	assign tacc     = (DVD_W+1)'(tprod) + (DVD_W+1)'(t_q);
	assign tacc_neg = -tacc;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			pacc_q <= pprod + DVD_W'(p_q);
			tneg_q <= tacc[DVD_W];
			tmag_q <= tacc[DVD_W] ? tacc_neg[DVD_W-1:0] : tacc[DVD_W-1:0];
			// a zero minimum counts as empty
			pmin_q <= (rd_pmin == '0 || p_q < rd_pmin) ? p_q : rd_pmin;
			pmax_q <= (p_q > rd_pmax) ? p_q : rd_pmax;
			tmin_q <= (rd_tmin == '0 || t_q < rd_tmin) ? t_q : rd_tmin;
			tmax_q <= (t_q > rd_tmax) ? t_q : rd_tmax;
		end
	end

	assign div_dividend = cmd.div_temp ? tmag_q : pacc_q;

	pbrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (n_q),
		.quotient (div_quo),
		.busy     (div_busy),
		.done     (div_done)
	);

	assign st.div_busy = div_busy;
	assign st.div_done = div_done;

	always_ff @(posedge clk) begin
		if (cmd.cap_mean) begin
			if (cmd.div_temp) begin
				tmean_q <= tneg_q ? -$signed(div_quo[TEMP_W-1:0])
					: $signed(div_quo[TEMP_W-1:0]);
			end else begin
				pmean_q <= div_quo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				pmean_mem[i] <= '0;
				pmin_mem[i]  <= '0;
				pmax_mem[i]  <= '0;
				tmean_mem[i] <= '0;
				tmin_mem[i]  <= '0;
				tmax_mem[i]  <= '0;
			end
		end else if (cmd.write && !bad_q) begin
			pmean_mem[bin_q] <= pmean_q;
			pmin_mem[bin_q]  <= pmin_q;
			pmax_mem[bin_q]  <= pmax_q;
			tmean_mem[bin_q] <= tmean_q;
			tmin_mem[bin_q]  <= tmin_q;
			tmax_mem[bin_q]  <= tmax_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			res_pmean_q <= bad_q ? '0 : pmean_q;
			res_pmin_q  <= bad_q ? '0 : pmin_q;
			res_pmax_q  <= bad_q ? '0 : pmax_q;
			res_tmean_q <= bad_q ? '0 : tmean_q;
			res_tmin_q  <= bad_q ? '0 : tmin_q;
			res_tmax_q  <= bad_q ? '0 : tmax_q;
		end
	end

	assign pressure_mean  = res_pmean_q;
	assign pressure_least = res_pmin_q;
	assign pressure_most  = res_pmax_q;
	assign temp_mean      = res_tmean_q;
	assign temp_least     = res_tmin_q;
	assign temp_most      = res_tmax_q;

endmodule

// File: rtl/pbrm_ctrl.sv
// ----------------------------------------------------------------------------
// pbrm_ctrl: sequencing state machine
// Steps one item through capture, multiply, two divisions and write-back.
// ----------------------------------------------------------------------------
module pbrm_ctrl import pbrm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	output pbrm_cmd_t    cmd,
	input  pbrm_status_t st
);

	pbrm_state_t state_q, state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIVP;
			end
			ST_DIVP: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVP_WAIT;
			end
			ST_DIVP_WAIT: begin
				if (st.div_done) begin
					cmd.cap_mean = 1'b1;
					state_d      = ST_DIVT;
				end
			end
			ST_DIVT: begin
				cmd.div_start = 1'b1;
				cmd.div_temp  = 1'b1;
				state_d       = ST_DIVT_WAIT;
			end
			ST_DIVT_WAIT: begin
				cmd.div_temp = 1'b1;
				if (st.div_done) begin
					cmd.cap_mean = 1'b1;
					state_d      = ST_WRITE;
				end
			end
			ST_WRITE: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.write = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transfer");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !st.div_busy)
		else $error("divider started while busy");

	a_load_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (cmd.mul && !in_ready))
		else $error("multiply step did not follow capture");

	a_done_cap: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> cmd.cap_mean)
		else $error("divider result not captured");

endmodule

// File: rtl/per_bin_running_mean_min_max.sv
// ----------------------------------------------------------------------------
// per_bin_running_mean_min_max: running pressure/temperature statistics per bin
// Flow: each sample passes through capture, a multiply step, two serial divisions
//   of 17 steps with start and capture each (sharing one divider), and a write.
// A new sample is accepted only after the previous one has been written back.
// Reset (arst_n low): all bin stores cleared to zero, controller idle, no result.
// ----------------------------------------------------------------------------
module per_bin_running_mean_min_max import pbrm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pbrm_in_if.sink    samples,
	pbrm_out_if.source results
);

	// Command and status between sequencer and datapath
	pbrm_cmd_t    cmd;
	pbrm_status_t st;

	// The controller accepts a sample only when idle; the result register in
	// the datapath lets a finished result wait while the next sample is taken.
	pbrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.st        (st)
	);

	// Datapath: stores for every bin, accumulators, divider, result register.
	// Samples naming a bin beyond the store leave it untouched and yield zeros.
	pbrm_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.day_bin         (samples.day_bin),
		.sample_count    (samples.sample_count),
		.pressure_sample (samples.pressure_sample),
		.temp_sample     (samples.temp_sample),
		.pressure_mean   (results.pressure_mean),
		.pressure_least  (results.pressure_least),
		.pressure_most   (results.pressure_most),
		.temp_mean       (results.temp_mean),
		.temp_least      (results.temp_least),
		.temp_most       (results.temp_most)
	);

endmodule
